// ===== rtl/ill_pkg.sv =====
// ----------------------------------------------------------------------------
// ill_pkg: shared definitions for the indexed linked list engine
// Request codes, result status codes and the controller state type.
// ----------------------------------------------------------------------------
package ill_pkg;

	// request codes
	localparam logic [2:0] FN_PUSH_BACK  = 3'd0;
	localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
	localparam logic [2:0] FN_INSERT     = 3'd2;
	localparam logic [2:0] FN_REMOVE     = 3'd3;
	localparam logic [2:0] FN_GET        = 3'd4;
	localparam logic [2:0] FN_SET        = 3'd5;
	localparam logic [2:0] FN_RANGE_DEL  = 3'd6;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_POS  = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_NODE_RD,
		S_ALLOC,
		S_LINK_RD,
		S_LINK_W1,
		S_LINK_W2,
		S_DROP,
		S_GET,
		S_RNG_RD,
		S_RNG_DEC
	} state_t;

endpackage

// ===== rtl/ill_ram.sv =====
// ----------------------------------------------------------------------------
// ill_ram: simple dual port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ill_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/indexed_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_linked_list_engine: circular doubly linked list in node memory
// Node value, next and prev links and the free stack live in synchronous RAMs;
// a sequencer walks and relinks the list one memory access at a time.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low. Exactly one result
// follows. It is shown for a single cycle with done high and cannot be stalled,
// so the receiver must take it in that cycle. Rejected requests (bad position,
// full store) and the unused code end straight from idle without a memory
// access. Push and insert allocate a node, then read the predecessor and write
// the links; on an empty list the node is linked to itself and the link writes
// are skipped. get and remove read the walked-to node; set writes it.
// insert, remove, get and set walk from the head at one link per cycle.
// remove_in_range reads each element that it visits and then drops it or steps
// past it. The walk rate is set by the registered read of the link RAM. busy
// falls in the done cycle.
module indexed_linked_list_engine #(
	parameter int NODES      = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [7:0]  position,
	input  logic [31:0] value,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	output logic        done,
	output logic [31:0] read_value,
	output logic [7:0]  length,
	output logic [1:0]  status
);

	localparam int IW   = $clog2(NODES);
	localparam int FW   = IW + 1;
	localparam int PW   = (IW > 8) ? IW : 8;
	localparam int CMPW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

	ill_pkg::state_t state_q, state_d;

	// request and list registers
	logic [2:0]            func_q, func_d;
	logic [7:0]            pos_q, pos_d;
	logic [VALUE_BITS-1:0] val_q, val_d;
	logic [31:0]           lo_q, lo_d, hi_q, hi_d;
	logic [IW-1:0]         head_q, head_d;
	logic [IW-1:0]         cnt_q, cnt_d;
	logic [FW-1:0]         fcnt_q, fcnt_d;
	logic [IW-1:0]         cur_q, cur_d;
	logic [IW-1:0]         k_q, k_d;
	logic [IW-1:0]         len_q, len_d;
	logic                  pend_q, pend_d;
	logic [IW-1:0]         new_q, new_d;
	logic [IW-1:0]         aft_q, aft_d;

	// result registers
	logic                  done_q;
	logic [31:0]           rv_q;
	logic [1:0]            stat_q;
	logic                  fin;
	logic [31:0]           rv_d;
	logic [1:0]            stat_d;

	// memory ports
	logic [IW-1:0]         nd_ra;
	logic [VALUE_BITS-1:0] rd_value;
	logic [IW-1:0]         rd_next, rd_prev;
	logic                  val_we, nxt_we, prv_we, fs_we;
	logic [IW-1:0]         val_wa, nxt_wa, prv_wa, fs_wa;
	logic [VALUE_BITS-1:0] val_wd;
	logic [IW-1:0]         nxt_wd, prv_wd, fs_wd;
	logic [IW-1:0]         fs_ra;
	logic [IW-1:0]         fs_rd;

	// helpers
	logic                  full;
	logic [PW-1:0]         pos_w, len_w, kp_w;
	logic [IW-1:0]         walk_c;
	logic                  in_rng;
	logic [IW-1:0]         after_n;

	ill_ram #(.DEPTH(NODES), .WIDTH(VALUE_BITS)) u_value (
		.clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
		.raddr(nd_ra), .rdata(rd_value)
	);

	ill_ram #(.DEPTH(NODES), .WIDTH(IW)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(nd_ra), .rdata(rd_next)
	);

	ill_ram #(.DEPTH(NODES), .WIDTH(IW)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.raddr(nd_ra), .rdata(rd_prev)
	);

	ill_ram #(.DEPTH(NODES), .WIDTH(IW)) u_free (
		.clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
		.raddr(fs_ra), .rdata(fs_rd)
	);

	assign busy       = (state_q != ill_pkg::S_IDLE);
	assign done       = done_q;
	assign read_value = rv_q;
	assign length     = 8'(cnt_q);
	assign status     = stat_q;

	assign full   = (cnt_q == IW'(NODES - 1));
	assign pos_w  = PW'(position);
	assign len_w  = PW'(cnt_q);
	assign kp_w   = PW'(k_q);
	assign walk_c = pend_q ? rd_next : cur_q;
	assign in_rng = (CMPW'(rd_value) >= CMPW'(lo_q)) && (CMPW'(rd_value) <= CMPW'(hi_q));

	// state and list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ill_pkg::S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			fcnt_q  <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			fcnt_q  <= fcnt_d;
			pend_q  <= pend_d;
			done_q  <= fin;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		func_q <= func_d;
		pos_q  <= pos_d;
		val_q  <= val_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		cur_q  <= cur_d;
		k_q    <= k_d;
		len_q  <= len_d;
		new_q  <= new_d;
		aft_q  <= aft_d;
		if (fin) begin
			rv_q   <= rv_d;
			stat_q <= stat_d;
		end
	end

	// sequencer: next state, memory accesses and result
	always_comb begin
		state_d = state_q;
		func_d  = func_q;
		pos_d   = pos_q;
		val_d   = val_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		head_d  = head_q;
		cnt_d   = cnt_q;
		fcnt_d  = fcnt_q;
		cur_d   = cur_q;
		k_d     = k_q;
		len_d   = len_q;
		pend_d  = 1'b0;
		new_d   = new_q;
		aft_d   = aft_q;
		fin     = 1'b0;
		rv_d    = '0;
		stat_d  = ill_pkg::STAT_OK;
		nd_ra   = cur_q;
		fs_ra   = IW'(fcnt_q - FW'(1));
		val_we  = 1'b0;
		val_wa  = cur_q;
		val_wd  = val_q;
		nxt_we  = 1'b0;
		nxt_wa  = new_q;
		nxt_wd  = new_q;
		prv_we  = 1'b0;
		prv_wa  = new_q;
		prv_wd  = new_q;
		fs_we   = 1'b0;
		fs_wa   = IW'(fcnt_q);
		fs_wd   = cur_q;
		after_n = '0;

		case (state_q)
			ill_pkg::S_IDLE: begin
				if (start) begin
					func_d = func;
					pos_d  = position;
					val_d  = VALUE_BITS'(value);
					lo_d   = range_low;
					hi_d   = range_high;
					cur_d  = head_q;
					k_d    = '0;
					len_d  = cnt_q;
					case (func)
						ill_pkg::FN_PUSH_BACK, ill_pkg::FN_PUSH_FRONT: begin
							if (full) begin
								fin    = 1'b1;
								stat_d = ill_pkg::STAT_FULL;
							end else begin
								state_d = ill_pkg::S_NODE_RD;
							end
						end
						ill_pkg::FN_INSERT: begin
							if (pos_w > len_w) begin
								fin    = 1'b1;
								stat_d = ill_pkg::STAT_BAD_POS;
							end else if (full) begin
								fin    = 1'b1;
								stat_d = ill_pkg::STAT_FULL;
							end else begin
								state_d = ill_pkg::S_WALK;
							end
						end
						ill_pkg::FN_REMOVE, ill_pkg::FN_GET, ill_pkg::FN_SET: begin
							if (pos_w >= len_w) begin
								fin    = 1'b1;
								stat_d = ill_pkg::STAT_BAD_POS;
							end else begin
								state_d = ill_pkg::S_WALK;
							end
						end
						ill_pkg::FN_RANGE_DEL: begin
							state_d = ill_pkg::S_RNG_RD;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end

			// follow one next link per cycle from the head
			ill_pkg::S_WALK: begin
				cur_d = walk_c;
				nd_ra = walk_c;
				if ((kp_w < PW'(pos_q)) && (walk_c != '0)) begin
					pend_d = 1'b1;
					k_d    = k_q + IW'(1);
				end else begin
					state_d = ill_pkg::S_NODE_RD;
				end
			end

			// read the target node (and the free stack top)
			ill_pkg::S_NODE_RD: begin
				case (func_q)
					ill_pkg::FN_REMOVE: state_d = ill_pkg::S_DROP;
					ill_pkg::FN_GET:    state_d = ill_pkg::S_GET;
					ill_pkg::FN_SET: begin
						val_we  = 1'b1;
						fin     = 1'b1;
						state_d = ill_pkg::S_IDLE;
					end
					default:            state_d = ill_pkg::S_ALLOC;
				endcase
			end

			// take a node, store the value, find the predecessor
			ill_pkg::S_ALLOC: begin
				if (fcnt_q != '0) begin
					new_d  = fs_rd;
					fcnt_d = fcnt_q - FW'(1);
				end else begin
					new_d  = cnt_q + IW'(1);
				end
				aft_d   = (cur_q != '0) ? rd_prev : '0;
				cnt_d   = cnt_q + IW'(1);
				val_we  = 1'b1;
				val_wa  = new_d;
				state_d = ill_pkg::S_LINK_RD;
			end

			ill_pkg::S_LINK_RD: begin
				nd_ra = aft_q;
				if (aft_q == '0) begin
					nxt_we  = 1'b1;
					prv_we  = 1'b1;
					fin     = 1'b1;
					state_d = ill_pkg::S_IDLE;
				end else begin
					state_d = ill_pkg::S_LINK_W1;
				end
			end

			// next[n] = x, prev[x] = n
			ill_pkg::S_LINK_W1: begin
				nxt_we  = 1'b1;
				nxt_wd  = rd_next;
				prv_we  = 1'b1;
				prv_wa  = rd_next;
				state_d = ill_pkg::S_LINK_W2;
			end

			// prev[n] = after, next[after] = n
			ill_pkg::S_LINK_W2: begin
				prv_we  = 1'b1;
				prv_wd  = aft_q;
				nxt_we  = 1'b1;
				nxt_wa  = aft_q;
				fin     = 1'b1;
				state_d = ill_pkg::S_IDLE;
			end

			// unlink the walked-to node and free it
			ill_pkg::S_DROP: begin
				nxt_we  = 1'b1;
				nxt_wa  = rd_prev;
				nxt_wd  = rd_next;
				prv_we  = 1'b1;
				prv_wa  = rd_next;
				prv_wd  = rd_prev;
				fs_we   = 1'b1;
				fcnt_d  = fcnt_q + FW'(1);
				cnt_d   = cnt_q - IW'(1);
				if (pos_q == '0) begin
					head_d = (cnt_q == IW'(1)) ? '0 : rd_next;
				end
				fin     = 1'b1;
				state_d = ill_pkg::S_IDLE;
			end

			ill_pkg::S_GET: begin
				rv_d    = 32'(rd_value);
				fin     = 1'b1;
				state_d = ill_pkg::S_IDLE;
			end

			// range removal: fetch the current node
			ill_pkg::S_RNG_RD: begin
				if ((k_q < len_q) && (cur_q != '0)) begin
					state_d = ill_pkg::S_RNG_DEC;
				end else begin
					fin     = 1'b1;
					state_d = ill_pkg::S_IDLE;
				end
			end

			// range removal: drop or step past the current node
			ill_pkg::S_RNG_DEC: begin
				k_d     = k_q + IW'(1);
				state_d = ill_pkg::S_RNG_RD;
				if (in_rng) begin
					nxt_we  = 1'b1;
					nxt_wa  = rd_prev;
					nxt_wd  = rd_next;
					prv_we  = 1'b1;
					prv_wa  = rd_next;
					prv_wd  = rd_prev;
					fs_we   = 1'b1;
					fcnt_d  = fcnt_q + FW'(1);
					cnt_d   = cnt_q - IW'(1);
					after_n = (cnt_q == IW'(1)) ? '0 : rd_next;
					cur_d   = after_n;
					if (cur_q == head_q) begin
						head_d = after_n;
					end
				end else begin
					cur_d = rd_next;
				end
			end

			default: begin
				state_d = ill_pkg::S_IDLE;
			end
		endcase

		// head update on completed link
		if (fin && ((state_q == ill_pkg::S_LINK_RD) || (state_q == ill_pkg::S_LINK_W2))) begin
			if (func_q == ill_pkg::FN_INSERT) begin
				if (pos_q == '0) begin
					head_d = new_q;
				end
			end else if ((func_q == ill_pkg::FN_PUSH_FRONT) || (head_q == '0)) begin
				head_d = new_q;
			end
		end
	end

endmodule
